FILE: hdl/text_console_cursor_controller_core_assert.svh
// ----------------------------------------------------------------------------
// text console cursor controller - assertion macros
// concurrent checks that vanish when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_CONTROLLER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_CONTROLLER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// consequent holds in the same cycle as the antecedent
`define TCCC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// consequent holds in the cycle after the antecedent
`define TCCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TCCC_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define TCCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: hdl/tccc_pkg.sv
// ----------------------------------------------------------------------------
// tccc_pkg
// shared types, register map and character codes of the cursor controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tccc_pkg;

  // default cursor coordinate width
  localparam int COORD_BITS_DEFAULT = 16;

  // configuration port geometry
  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 32;

  // register indexes
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [2:0] REG_GLYPH_SCALE   = 3'd2;
  localparam logic [2:0] REG_FONT_W        = 3'd3;
  localparam logic [2:0] REG_FONT_H        = 3'd4;
  localparam logic [2:0] REG_HOME_X        = 3'd5;
  localparam logic [2:0] REG_HOME_Y        = 3'd6;

  // register reset values
  localparam logic [13:0] SCREEN_WIDTH_RESET  = 14'd1024;
  localparam logic [13:0] SCREEN_HEIGHT_RESET = 14'd768;
  localparam logic [3:0]  GLYPH_SCALE_RESET   = 4'd1;
  localparam logic [4:0]  FONT_W_RESET        = 5'd8;
  localparam logic [5:0]  FONT_H_RESET        = 6'd16;
  localparam logic [12:0] HOME_X_RESET        = 13'd0;
  localparam logic [12:0] HOME_Y_RESET        = 13'd0;

  // control characters
  localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [7:0] CHAR_TAB       = 8'd9;
  localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [7:0] CHAR_RETURN    = 8'd13;

  // cell geometry constants
  localparam int LINE_GAP       = 4;
  localparam int TAB_CELLS      = 4;
  localparam int NEWLINE_EXTRA  = 2;

  // character class decided by the front end
  typedef enum logic [2:0] {
    KIND_NEWLINE,
    KIND_RETURN,
    KIND_TAB,
    KIND_BACKSPACE,
    KIND_PRINT
  } kind_t;

  // renderer commands
  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_DRAW   = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_SCROLL = 2'd3
  } action_t;

  // classified item held in the queue
  typedef struct packed {
    kind_t      kind;
    logic       home;
    logic       draw;
    logic [6:0] glyph;
  } item_t;

  // screen and cell geometry seen by the back end
  typedef struct packed {
    logic [13:0] screen_width;
    logic [13:0] screen_height;
    logic [8:0]  cell_width;
    logic [9:0]  scroll_rows;
    logic [9:0]  cell_height;
    logic [12:0] home_x;
    logic [12:0] home_y;
  } geom_t;

  // one renderer command
  typedef struct packed {
    action_t     action;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [6:0]  glyph;
    logic [15:0] scroll_rows;
    logic        last;
  } result_t;

endpackage

FILE: hdl/tccc_if.sv
// ----------------------------------------------------------------------------
// tccc channel interfaces
// character input channel and renderer command channel, valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tccc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       cursor_home;

  modport source (output valid, ch, cursor_home, input ready);
  modport sink   (input valid, ch, cursor_home, output ready);
endinterface

interface tccc_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [6:0]  glyph;
  logic [15:0] scroll_rows;
  logic        last;

  modport source (output valid, action, pos_x, pos_y, glyph, scroll_rows, last,
                  input ready);
  modport sink   (input valid, action, pos_x, pos_y, glyph, scroll_rows, last,
                  output ready);
endinterface

FILE: hdl/text_console_cursor_controller_core.sv
// ----------------------------------------------------------------------------
// text_console_cursor_controller_core
// character stream in, renderer commands out, cursor kept in pixels
// ----------------------------------------------------------------------------
// channel   dir  handshake            payload
// char_in   in   valid/ready          ch, cursor_home
// cmd_out   out  valid/ready          action, pos_x, pos_y, glyph, scroll_rows, last
// apb       in   psel/penable/pwrite  paddr, pwdata, prdata (pready tied high)
//
// back end takes one character a cycle unless cmd_out stalls or a command pends
// a scroll plus a draw gives two commands, one per cycle while cmd_out is ready
// first command is valid after the character passes the queue and output reg
// char_in.ready follows only the two-entry queue fill, never cmd_out.ready
// synchronous reset, no clearing pass; cursor goes to reset home
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_cursor_controller_core #(
  parameter int COORD_BITS = tccc_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  tccc_char_if.sink                            char_in,
  tccc_cmd_if.source                           cmd_out,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tccc_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [tccc_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [tccc_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                 pready
);
  import tccc_pkg::*;

  geom_t geom;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  // configuration registers
  tccc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geom    (geom)
  );

  // accept and classify
  tccc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .char_in (char_in),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // cursor and command issue
  tccc_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .geom    (geom),
    .cmd_out (cmd_out)
  );

endmodule

FILE: hdl/tccc_cfg.sv
// ----------------------------------------------------------------------------
// tccc_cfg
// apb register file with cell geometry worked out as registers are written
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tccc_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tccc_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [tccc_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [tccc_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                 pready,
  output tccc_pkg::geom_t                      geom
);
  import tccc_pkg::*;

  logic [13:0] screen_width, screen_width_next;
  logic [13:0] screen_height, screen_height_next;
  logic [3:0]  glyph_scale, glyph_scale_next;
  logic [4:0]  font_w, font_w_next;
  logic [5:0]  font_h, font_h_next;
  logic [12:0] home_x, home_x_next;
  logic [12:0] home_y, home_y_next;
  logic [8:0]  cell_width, cell_width_next;
  logic [9:0]  scroll_rows, scroll_rows_next;
  logic [9:0]  cell_height, cell_height_next;
  logic [3:0]  scale_eff;
  logic [2:0]  reg_idx;
  logic        wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_BITS-1:2];
  assign wr      = psel && penable && pwrite;

  // register next values
  assign screen_width_next  = (wr && reg_idx == REG_SCREEN_WIDTH)  ? pwdata[13:0] : screen_width;
  assign screen_height_next = (wr && reg_idx == REG_SCREEN_HEIGHT) ? pwdata[13:0] : screen_height;
  assign glyph_scale_next   = (wr && reg_idx == REG_GLYPH_SCALE)   ? pwdata[3:0]  : glyph_scale;
  assign font_w_next        = (wr && reg_idx == REG_FONT_W)        ? pwdata[4:0]  : font_w;
  assign font_h_next        = (wr && reg_idx == REG_FONT_H)        ? pwdata[5:0]  : font_h;
  assign home_x_next        = (wr && reg_idx == REG_HOME_X)        ? pwdata[12:0] : home_x;
  assign home_y_next        = (wr && reg_idx == REG_HOME_Y)        ? pwdata[12:0] : home_y;

  // cell geometry from the values being written, scale zero acts as one
  assign scale_eff        = (glyph_scale_next == 4'd0) ? 4'd1 : glyph_scale_next;
  assign cell_width_next  = 9'(font_w_next) * 9'(scale_eff);
  assign scroll_rows_next = 10'(font_h_next) * 10'(scale_eff);
  assign cell_height_next = scroll_rows_next + 10'(LINE_GAP);

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RESET;
      screen_height <= SCREEN_HEIGHT_RESET;
      glyph_scale   <= GLYPH_SCALE_RESET;
      font_w        <= FONT_W_RESET;
      font_h        <= FONT_H_RESET;
      home_x        <= HOME_X_RESET;
      home_y        <= HOME_Y_RESET;
      cell_width    <= 9'(FONT_W_RESET) * 9'(GLYPH_SCALE_RESET);
      scroll_rows   <= 10'(FONT_H_RESET) * 10'(GLYPH_SCALE_RESET);
      cell_height   <= 10'(FONT_H_RESET) * 10'(GLYPH_SCALE_RESET) + 10'(LINE_GAP);
    end else begin
      screen_width  <= screen_width_next;
      screen_height <= screen_height_next;
      glyph_scale   <= glyph_scale_next;
      font_w        <= font_w_next;
      font_h        <= font_h_next;
      home_x        <= home_x_next;
      home_y        <= home_y_next;
      cell_width    <= cell_width_next;
      scroll_rows   <= scroll_rows_next;
      cell_height   <= cell_height_next;
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_SCREEN_WIDTH:  prdata = CFG_DATA_BITS'(screen_width);
      REG_SCREEN_HEIGHT: prdata = CFG_DATA_BITS'(screen_height);
      REG_GLYPH_SCALE:   prdata = CFG_DATA_BITS'(glyph_scale);
      REG_FONT_W:        prdata = CFG_DATA_BITS'(font_w);
      REG_FONT_H:        prdata = CFG_DATA_BITS'(font_h);
      REG_HOME_X:        prdata = CFG_DATA_BITS'(home_x);
      REG_HOME_Y:        prdata = CFG_DATA_BITS'(home_y);
      default:           prdata = '0;
    endcase
  end

  // geometry to the back end
  assign geom.screen_width  = screen_width;
  assign geom.screen_height = screen_height;
  assign geom.cell_width    = cell_width;
  assign geom.scroll_rows   = scroll_rows;
  assign geom.cell_height   = cell_height;
  assign geom.home_x        = home_x;
  assign geom.home_y        = home_y;

endmodule

FILE: hdl/tccc_front.sv
// ----------------------------------------------------------------------------
// tccc_front
// accepts characters, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_console_cursor_controller_core_assert.svh"

module tccc_front (
  input  logic              clk,
  input  logic              rst,
  tccc_char_if.sink         char_in,
  output logic              q_valid,
  output tccc_pkg::item_t   q_item,
  input  logic              q_pop
);
  import tccc_pkg::*;

  localparam int DEPTH    = 2;
  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  item_t               slots [DEPTH];
  item_t               item_in;
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                push;

  assign char_in.ready = (count != CNT_BITS'(DEPTH));
  assign push          = char_in.valid && char_in.ready;

  // classify the incoming character
  always_comb begin
    item_in.home  = char_in.cursor_home;
    item_in.draw  = !char_in.ch[7];
    item_in.glyph = char_in.ch[6:0];
    case (char_in.ch)
      CHAR_NEWLINE:   item_in.kind = KIND_NEWLINE;
      CHAR_RETURN:    item_in.kind = KIND_RETURN;
      CHAR_TAB:       item_in.kind = KIND_TAB;
      CHAR_BACKSPACE: item_in.kind = KIND_BACKSPACE;
      default:        item_in.kind = KIND_PRINT;
    endcase
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  assign q_valid = (count != '0);
  assign q_item  = slots[rd_ptr];

  // checks
  `TCCC_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= CNT_BITS'(DEPTH), "queue overfilled")
  `TCCC_ASSERT_NEXT(a_count_grow, clk, rst, push && !q_pop, count == $past(count) + 1'b1, "queue count did not grow")
  `TCCC_ASSERT_SAME(a_pop_nonempty, clk, rst, q_pop, q_valid, "pop from empty queue")

endmodule

FILE: hdl/tccc_back.sv
// ----------------------------------------------------------------------------
// tccc_back
// keeps the cursor, carries out queued items and issues renderer commands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_console_cursor_controller_core_assert.svh"

module tccc_back #(
  parameter int COORD_BITS = tccc_pkg::COORD_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  tccc_pkg::item_t   q_item,
  output logic              q_pop,
  input  tccc_pkg::geom_t   geom,
  tccc_cmd_if.source        cmd_out
);
  import tccc_pkg::*;

  // compare width: unwrapped coordinate sums and the screen size both fit
  localparam int SB = (COORD_BITS >= 14) ? COORD_BITS + 1 : 15;

  logic [COORD_BITS-1:0] cursor_x, cursor_x_next;
  logic [COORD_BITS-1:0] cursor_y, cursor_y_next;
  logic [COORD_BITS-1:0] hxw, hyw, x0, y0, y_adv, x_tab, x1, y1, y2;
  logic [SB-1:0]         cw_e, chh_e, sw_e, sh_e, pull_e, sw_back;
  logic                  adv_scroll, tab_wrap, pr_wrap, pr_scroll;
  result_t               res0, res1, res_none, res_scroll;
  logic                  two;
  result_t               out_q, pend_q;
  logic                  out_valid, pend_valid, out_load;

  // geometry at compare width
  assign cw_e    = SB'(geom.cell_width);
  assign chh_e   = SB'(geom.cell_height);
  assign sw_e    = SB'(geom.screen_width);
  assign sh_e    = SB'(geom.screen_height);
  assign pull_e  = chh_e + SB'(NEWLINE_EXTRA);
  assign sw_back = (sw_e >= cw_e) ? sw_e - cw_e : '0;
  assign hxw     = COORD_BITS'(geom.home_x);
  assign hyw     = COORD_BITS'(geom.home_y);

  // starting point, homed if asked
  assign x0 = q_item.home ? hxw : cursor_x;
  assign y0 = q_item.home ? hyw : cursor_y;

  // shared line advance and its scroll test
  assign y_adv      = COORD_BITS'(SB'(y0) + chh_e);
  assign adv_scroll = (SB'(y_adv) + chh_e) > sh_e;

  // tab step
  assign x_tab    = COORD_BITS'(SB'(x0) + cw_e * SB'(TAB_CELLS));
  assign tab_wrap = (SB'(x_tab) + cw_e) > sw_e;

  // printable: wrap, then scroll
  assign pr_wrap   = (SB'(x0) + cw_e) > sw_e;
  assign x1        = pr_wrap ? hxw : x0;
  assign y1        = pr_wrap ? y_adv : y0;
  assign pr_scroll = (SB'(y1) + chh_e) > sh_e;
  assign y2        = !pr_scroll ? y1 :
                     (SB'(y1) >= chh_e) ? COORD_BITS'(SB'(y1) - chh_e) : '0;

  // fixed commands
  always_comb begin
    res_none             = '0;
    res_none.action      = ACT_NONE;
    res_none.last        = 1'b1;
    res_scroll           = '0;
    res_scroll.action    = ACT_SCROLL;
    res_scroll.scroll_rows = 16'(geom.scroll_rows);
    res_scroll.last      = 1'b1;
  end

  // execute one item
  always_comb begin
    cursor_x_next = x0;
    cursor_y_next = y0;
    res0          = res_none;
    res1          = res_none;
    two           = 1'b0;
    case (q_item.kind)
      KIND_NEWLINE: begin
        cursor_x_next = hxw;
        cursor_y_next = y_adv;
        if (adv_scroll) begin
          res0 = res_scroll;
          cursor_y_next = (SB'(y_adv) >= pull_e) ? COORD_BITS'(SB'(y_adv) - pull_e) : '0;
        end
      end
      KIND_RETURN: begin
        cursor_x_next = hxw;
      end
      KIND_TAB: begin
        if (tab_wrap) begin
          cursor_x_next = hxw;
          cursor_y_next = y_adv;
        end else begin
          cursor_x_next = x_tab;
        end
      end
      KIND_BACKSPACE: begin
        if (SB'(x0) >= cw_e) begin
          cursor_x_next = COORD_BITS'(SB'(x0) - cw_e);
        end else if (SB'(y0) >= chh_e) begin
          cursor_y_next = COORD_BITS'(SB'(y0) - chh_e);
          cursor_x_next = COORD_BITS'(sw_back);
        end else begin
          cursor_x_next = hxw;
        end
        res0        = '0;
        res0.action = ACT_CLEAR;
        res0.pos_x  = 16'(cursor_x_next);
        res0.pos_y  = 16'(cursor_y_next);
        res0.last   = 1'b1;
      end
      KIND_PRINT: begin
        cursor_x_next = COORD_BITS'(SB'(x1) + cw_e);
        cursor_y_next = y2;
        if (pr_scroll) begin
          res0 = res_scroll;
        end
        if (q_item.draw) begin
          res1        = '0;
          res1.action = ACT_DRAW;
          res1.pos_x  = 16'(x1);
          res1.pos_y  = 16'(y2);
          res1.glyph  = q_item.glyph;
          res1.last   = 1'b1;
          if (pr_scroll) begin
            res0.last = 1'b0;
            two       = 1'b1;
          end else begin
            res0 = res1;
          end
        end
      end
      default: begin
        cursor_x_next = x0;
      end
    endcase
  end

  // output register plus a slot for a second command
  assign out_load = !out_valid || cmd_out.ready;
  assign q_pop    = out_load && !pend_valid && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x   <= COORD_BITS'(HOME_X_RESET);
      cursor_y   <= COORD_BITS'(HOME_Y_RESET);
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        cursor_x <= cursor_x_next;
        cursor_y <= cursor_y_next;
      end
      if (out_load) begin
        if (pend_valid) begin
          out_valid  <= 1'b1;
          pend_valid <= 1'b0;
        end else if (q_valid) begin
          out_valid  <= 1'b1;
          pend_valid <= two;
        end else begin
          out_valid  <= 1'b0;
        end
      end
    end
  end

  // command payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (pend_valid) begin
        out_q <= pend_q;
      end else if (q_valid) begin
        out_q  <= res0;
        pend_q <= res1;
      end
    end
  end

  assign cmd_out.valid       = out_valid;
  assign cmd_out.action      = out_q.action;
  assign cmd_out.pos_x       = out_q.pos_x;
  assign cmd_out.pos_y       = out_q.pos_y;
  assign cmd_out.glyph       = out_q.glyph;
  assign cmd_out.scroll_rows = out_q.scroll_rows;
  assign cmd_out.last        = out_q.last;

  // checks
  `TCCC_ASSERT_SAME(a_pend_behind_out, clk, rst, pend_valid, out_valid, "second command without a first")
  `TCCC_ASSERT_SAME(a_no_pop_pending, clk, rst, pend_valid, !q_pop, "item taken while a command waits")
  `TCCC_ASSERT_SAME(a_not_last_pends, clk, rst, out_valid && !out_q.last, pend_valid, "non-last command with no follower")

endmodule
